>>> hdl/pde_pkg.sv
// Shared types, widths and helpers for the polynomial derivative evaluator.
// Used by pde_prep, pde_step and poly_derivative_eval; depends on nothing.

package pde_pkg;

  // falling factorial (base+order)!/base!, used at elaboration only
  function automatic int fall_fac(input int base, input int order);
    int acc;
    int j;
    acc = 1;
    for (j = 1; j <= order; j++) begin
      acc = acc * (base + j);
    end
    return acc;
  endfunction

  localparam int MAX_DEGREE = 5;
  localparam int NUM_TERMS  = MAX_DEGREE + 1;

  localparam int DATA_W  = 32;
  localparam int TIME_W  = 31;
  localparam int ORDER_W = 3;
  localparam int DEG_W   = 3;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = DEG_W + 1;

  localparam int NUM_ORDERS = 2 ** ORDER_W;

  localparam int FAC_W   = $clog2(fall_fac(0, MAX_DEGREE) + 1);
  localparam int SCALE_W = DATA_W + FAC_W + 1;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int WIDE_W  = PROD_W - FRAC_W + 1;

  // half an LSB of the result, added before the shift for round-half-up
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  localparam int CFG_IDX_W = $clog2(NUM_TERMS + 2);

  // total register depth of prep and of all Horner steps
  localparam int PIPE_LAT = 2 + 2 * NUM_TERMS;

  // configuration register map; coefficients follow the base index
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE    = 0,
    CFG_DURATION  = 1,
    CFG_COEF_BASE = 2
  } cfg_reg_e;

  typedef logic [NUM_TERMS-1:0][DATA_W-1:0] coef_vec_t;

  typedef struct packed {
    logic [DEG_W-1:0]  degree;
    logic [TIME_W-1:0] duration_limit;
    coef_vec_t         coef;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] time_point;
    logic [ORDER_W-1:0]       deriv_order;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     overflow;
  } res_t;

  // one beat in flight through the Horner chain; top lane sits at the MSB
  typedef struct packed {
    logic [TIME_W-1:0]        t;
    logic [NUM_TERMS-1:0]     en;
    coef_vec_t                d;
    logic signed [DATA_W-1:0] acc;
    logic                     ovf;
  } beat_t;

  // saturate a wide signed value to DATA_W; MSB of the result flags clipping
  function automatic logic [DATA_W:0] sat_wide(input logic signed [WIDE_W-1:0] x);
    logic clip;
    clip = !((&x[WIDE_W-1:DATA_W-1]) || !(|x[WIDE_W-1:DATA_W-1]));
    if (!clip) begin
      return {1'b0, x[DATA_W-1:0]};
    end else if (x[WIDE_W-1]) begin
      return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> hdl/pde_prep.sv
// Front end of the evaluator: time clamp, lane enables, derivative coefficients.
// Two register stages. Depends on pde_pkg.

module pde_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  pde_pkg::cmd_t    cmd_i,
  input  pde_pkg::cfg_t    cfg_i,
  output logic             valid_o,
  output pde_pkg::beat_t   beat_o
);

  // stage 1 registers
  logic                            v1_q;
  logic [pde_pkg::TIME_W-1:0]      t1_q, t1_d;
  logic [pde_pkg::ORDER_W-1:0]     n1_q;
  logic [pde_pkg::NUM_TERMS-1:0]   en1_q, en1_d;
  logic [pde_pkg::DEG_W-1:0]       deg_eff;

  // stage 2 registers
  logic                            v2_q;
  pde_pkg::beat_t                  beat_q, beat_d;

  pde_pkg::coef_vec_t              d2;
  logic [pde_pkg::NUM_TERMS-1:0]   lane_ovf;

  // clamp time, cap degree, enable lanes with i + n <= degree
  always_comb begin
    deg_eff = (cfg_i.degree > pde_pkg::DEG_W'(pde_pkg::MAX_DEGREE)) ?
              pde_pkg::DEG_W'(pde_pkg::MAX_DEGREE) : cfg_i.degree;
    if (cmd_i.time_point[pde_pkg::DATA_W-1]) begin
      t1_d = '0;
    end else if (cmd_i.time_point[pde_pkg::TIME_W-1:0] > cfg_i.duration_limit) begin
      t1_d = cfg_i.duration_limit;
    end else begin
      t1_d = cmd_i.time_point[pde_pkg::TIME_W-1:0];
    end
    for (int i = 0; i < pde_pkg::NUM_TERMS; i++) begin
      en1_d[i] = (pde_pkg::SUM_W'(i) + pde_pkg::SUM_W'(cmd_i.deriv_order))
                 <= pde_pkg::SUM_W'(deg_eff);
    end
  end

  // scale coef[i+n] by (i+n)!/i! in each lane
  for (genvar i = 0; i < pde_pkg::NUM_TERMS; i++) begin : g_lane
    logic [pde_pkg::DATA_W-1:0]        cand [pde_pkg::NUM_ORDERS];
    logic [pde_pkg::FAC_W-1:0]         fac_tab [pde_pkg::NUM_ORDERS];
    logic [pde_pkg::DATA_W-1:0]        sel;
    logic [pde_pkg::FAC_W-1:0]         fac;
    logic signed [pde_pkg::SCALE_W-1:0] prod;
    logic [pde_pkg::DATA_W:0]          sat;

    for (genvar k = 0; k < pde_pkg::NUM_ORDERS; k++) begin : g_ord
      if (i + k < pde_pkg::NUM_TERMS) begin : g_in
        assign cand[k]    = cfg_i.coef[i + k];
        assign fac_tab[k] = pde_pkg::FAC_W'(pde_pkg::fall_fac(i, k));
      end else begin : g_out
        assign cand[k]    = '0;
        assign fac_tab[k] = '0;
      end
    end

    assign sel  = cand[n1_q];
    assign fac  = fac_tab[n1_q];
    assign prod = $signed(sel) * $signed({1'b0, fac});
    assign sat  = pde_pkg::sat_wide(pde_pkg::WIDE_W'(prod));
    assign d2[i]       = sat[pde_pkg::DATA_W-1:0];
    assign lane_ovf[i] = sat[pde_pkg::DATA_W] & en1_q[i];
  end

  // assemble the beat for the Horner chain
  always_comb begin
    beat_d     = '0;
    beat_d.t   = t1_q;
    beat_d.en  = en1_q;
    beat_d.d   = d2;
    beat_d.acc = '0;
    beat_d.ovf = |lane_ovf;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // payload, advances every cycle
  always_ff @(posedge clk_i) begin
    t1_q   <= t1_d;
    n1_q   <= cmd_i.deriv_order;
    en1_q  <= en1_d;
    beat_q <= beat_d;
  end

  assign valid_o = v2_q;
  assign beat_o  = beat_q;

endmodule

>>> hdl/pde_step.sv
// One Horner step: acc = sat(round(acc * t / 2^16) + d) for the top lane.
// Multiply stage, then round/add/saturate stage. Depends on pde_pkg.

module pde_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  pde_pkg::beat_t beat_i,
  output logic           valid_o,
  output pde_pkg::beat_t beat_o
);

  logic                                vm_q;
  pde_pkg::beat_t                      bm_q;
  logic signed [pde_pkg::PROD_W-1:0]   prod_q, prod_d;

  logic                                va_q;
  pde_pkg::beat_t                      ba_q, ba_d;

  logic signed [pde_pkg::PROD_W-1:0]   rounded;
  logic signed [pde_pkg::WIDE_W-1:0]   sum;
  logic [pde_pkg::DATA_W:0]            sat;
  logic [pde_pkg::DATA_W-1:0]          d_top;

  // multiply accumulator by the clamped time (time is non-negative)
  assign prod_d = beat_i.acc * $signed({1'b0, beat_i.t});

  // round to nearest, ties up, then add the lane coefficient
  assign d_top   = bm_q.d[pde_pkg::NUM_TERMS-1];
  assign rounded = prod_q + pde_pkg::ROUND_HALF;
  assign sum     = pde_pkg::WIDE_W'($signed(rounded[pde_pkg::PROD_W-1:pde_pkg::FRAC_W]))
                 + pde_pkg::WIDE_W'($signed(d_top));
  assign sat     = pde_pkg::sat_wide(sum);

  // update only when this lane is in use; shift the next lane to the top
  always_comb begin
    ba_d    = bm_q;
    if (bm_q.en[pde_pkg::NUM_TERMS-1]) begin
      ba_d.acc = sat[pde_pkg::DATA_W-1:0];
      ba_d.ovf = bm_q.ovf | sat[pde_pkg::DATA_W];
    end
    ba_d.d  = bm_q.d << pde_pkg::DATA_W;
    ba_d.en = bm_q.en << 1;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      va_q <= 1'b0;
    end else begin
      vm_q <= valid_i;
      va_q <= vm_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    bm_q   <= beat_i;
    prod_q <= prod_d;
    ba_q   <= ba_d;
  end

  assign valid_o = va_q;
  assign beat_o  = ba_q;

endmodule

>>> hdl/poly_derivative_eval.sv
// Top level of the polynomial derivative evaluator: config registers,
// front end and the Horner step chain. Depends on pde_pkg, pde_prep, pde_step.
//
// Usage:
//   Command channel: drive cmd_i (time_point, deriv_order) and raise start_i;
//   the beat is taken at that edge. busy_o stays low, so a new command can
//   enter in every cycle.
//   Result channel: done_o is high for exactly one cycle with result_o
//   (value, overflow) valid. The receiver cannot stall and must take it.
//   Pipeline: a command passes the prep register stages, then the multiply
//   and round/add/saturate stages of every Horner step before done_o, the
//   same path for every configured degree and derivative order.
//   Throughput: one beat per cycle, set by the fully pipelined chain of one
//   multiply stage and one round/add/saturate stage per Horner step.
//   Config port: cfg_we_i, cfg_idx_i, cfg_data_i write one register per
//   cycle: degree, duration limit, then coefficients 0 upward. Write only
//   while no command is in flight.
//   Reset: asynchronous, active low; clears config registers and valid bits,
//   not payload. Results start only after the first accepted command.

module poly_derivative_eval (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  pde_pkg::cmd_t                   cmd_i,
  output logic                            done_o,
  output pde_pkg::res_t                   result_o,
  input  logic                            cfg_we_i,
  input  logic [pde_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pde_pkg::DATA_W-1:0]      cfg_data_i
);

  logic [pde_pkg::DEG_W-1:0]   degree_q;
  logic [pde_pkg::TIME_W-1:0]  duration_q;
  pde_pkg::coef_vec_t          coef_q;
  pde_pkg::cfg_t               cfg;

  logic [pde_pkg::NUM_TERMS:0] vchain;
  pde_pkg::beat_t              bchain [pde_pkg::NUM_TERMS+1];

  logic [pde_pkg::DEG_W-1:0]   deg_eff;

  assign busy_o = 1'b0;

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q   <= '0;
      duration_q <= '0;
      coef_q     <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pde_pkg::CFG_DEGREE) begin
        degree_q <= cfg_data_i[pde_pkg::DEG_W-1:0];
      end else if (cfg_idx_i == pde_pkg::CFG_DURATION) begin
        duration_q <= cfg_data_i[pde_pkg::TIME_W-1:0];
      end else begin
        for (int k = 0; k < pde_pkg::NUM_TERMS; k++) begin
          if (cfg_idx_i == pde_pkg::CFG_IDX_W'(pde_pkg::CFG_COEF_BASE + k)) begin
            coef_q[k] <= cfg_data_i;
          end
        end
      end
    end
  end

  assign cfg.degree         = degree_q;
  assign cfg.duration_limit = duration_q;
  assign cfg.coef           = coef_q;

  // front end
  pde_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .cmd_i   (cmd_i),
    .cfg_i   (cfg),
    .valid_o (vchain[0]),
    .beat_o  (bchain[0])
  );

  // Horner chain, highest lane first
  for (genvar s = 0; s < pde_pkg::NUM_TERMS; s++) begin : g_step
    pde_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vchain[s]),
      .beat_i  (bchain[s]),
      .valid_o (vchain[s+1]),
      .beat_o  (bchain[s+1])
    );
  end

  assign done_o            = vchain[pde_pkg::NUM_TERMS];
  assign result_o.value    = bchain[pde_pkg::NUM_TERMS].acc;
  assign result_o.overflow = bchain[pde_pkg::NUM_TERMS].ovf;

  // checks
  assign deg_eff = (degree_q > pde_pkg::DEG_W'(pde_pkg::MAX_DEGREE)) ?
                   pde_pkg::DEG_W'(pde_pkg::MAX_DEGREE) : degree_q;

  a_done_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, pde_pkg::PIPE_LAT))
    else $error("result beat without a matching command");

  a_cmd_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(pde_pkg::PIPE_LAT) done_o)
    else $error("command beat lost in the pipeline");

  a_high_order_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(cmd_i.deriv_order, pde_pkg::PIPE_LAT) > deg_eff))
      |-> (result_o.value == '0) && !result_o.overflow)
    else $error("order above degree must give zero");

endmodule

>>> bench/pde_checker.sv
// Result checker for poly_derivative_eval: mirrors the config registers,
// predicts each accepted command and compares every done beat in order.
// Depends on pde_pkg for the register map and the command/result types.

module pde_checker
  import pde_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  cmd_t                 cmd_i,
  input  logic                 done_i,
  input  res_t                 result_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output int                   pending_o,
  output int                   fails_o
);

  logic [DEG_W-1:0]         degree_q;
  logic [TIME_W-1:0]        duration_q;
  logic signed [DATA_W-1:0] coef_q [NUM_TERMS];

  res_t expected_results [$];
  int   pending_count;
  int   fail_count;

  assign pending_o = pending_count;
  assign fails_o   = fail_count;

  // clip to the signed 32-bit range, flag when clipped
  function automatic longint clip32(input longint v, output bit hit);
    hit = 1'b0;
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // n-th derivative at the clamped time, Horner from the top term down
  function automatic res_t eval_derivative(input cmd_t c);
    res_t   r;
    longint t;
    longint acc;
    longint d;
    longint fac;
    longint prod;
    int     deg;
    int     n;
    int     top;
    int     i;
    int     j;
    bit     hit;
    bit     ovf;
    deg = (int'(degree_q) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_q);
    n   = int'(c.deriv_order);
    t   = longint'($signed(c.time_point));
    if (t < 0) begin
      t = 0;
    end else if (t > longint'(duration_q)) begin
      t = longint'(duration_q);
    end
    acc = 0;
    ovf = 1'b0;
    if (n <= deg) begin
      top = deg - n;
      for (i = top; i >= 0; i--) begin
        fac = 1;
        for (j = 1; j <= n; j++) begin
          fac = fac * (i + j);
        end
        d = clip32(longint'(coef_q[i + n]) * fac, hit);
        ovf |= hit;
        if (i == top) begin
          acc = d;
        end else begin
          // round to nearest, ties toward +inf, then add the next term
          prod = acc * t + 64'sh8000;
          acc  = clip32((prod >>> FRAC_W) + d, hit);
          ovf |= hit;
        end
      end
    end
    r.value    = acc[DATA_W-1:0];
    r.overflow = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    int   k;
    if (!rst_ni) begin
      degree_q   = '0;
      duration_q = '0;
      for (k = 0; k < NUM_TERMS; k++) begin
        coef_q[k] = '0;
      end
      expected_results.delete();
      pending_count = 0;
      fail_count    = 0;
    end else begin
      // compare the done beat against the oldest prediction
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: value %0d overflow %0b",
                 $signed(result_i.value), result_i.overflow);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_i.value !== exp_r.value) begin
            $error("value: expected %0d, got %0d",
                   $signed(exp_r.value), $signed(result_i.value));
            fail_count++;
          end
          if (result_i.overflow !== exp_r.overflow) begin
            $error("overflow: expected %0b, got %0b",
                   exp_r.overflow, result_i.overflow);
            fail_count++;
          end
        end
      end
      // predict with the registers as they stand before this edge
      if (start_i && !busy_i) begin
        expected_results.insert(expected_results.size(), eval_derivative(cmd_i));
      end
      // mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEGREE: begin
            degree_q = cfg_data_i[DEG_W-1:0];
          end
          CFG_DURATION: begin
            duration_q = cfg_data_i[TIME_W-1:0];
          end
          default: begin
            k = int'(cfg_idx_i) - int'(CFG_COEF_BASE);
            if (k >= 0 && k < NUM_TERMS) begin
              coef_q[k] = cfg_data_i;
            end
          end
        endcase
      end
      pending_count = expected_results.size();
    end
  end

endmodule

>>> bench/tb_poly_derivative_eval.sv
// Testbench top for poly_derivative_eval: clock, reset, config settings and
// command stimulus; checking is done by pde_checker. Depends on pde_pkg.

module tb_poly_derivative_eval;
  import pde_pkg::*;

  localparam int RAND_SETTINGS = 10;
  localparam int CMDS_PER_SET  = 65;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 start    = 1'b0;
  logic                 busy;
  cmd_t                 cmd      = '0;
  logic                 done;
  res_t                 result;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  int                   pending;
  int                   fails;

  // register values for the next setting
  logic [DEG_W-1:0]     set_degree;
  logic [TIME_W-1:0]    set_duration;
  logic [DATA_W-1:0]    set_coef [NUM_TERMS];
  int                   idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  poly_derivative_eval dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pde_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .cmd_i      (cmd),
    .done_i     (done),
    .result_i   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .fails_o    (fails)
  );

  // hold one register write for a single edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // drain the pipeline, then write every register; junk in unused upper bits
  task automatic load_setting();
    int k;
    start <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    write_reg(CFG_DEGREE, {29'($urandom), set_degree});
    write_reg(CFG_DURATION, {1'($urandom_range(1)), set_duration});
    for (k = 0; k < NUM_TERMS; k++) begin
      write_reg(CFG_IDX_W'(int'(CFG_COEF_BASE) + k), set_coef[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // idle at random, then present one command beat until it is taken
  task automatic issue_cmd(input logic [DATA_W-1:0] tp, input int order);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    cmd.time_point    <= tp;
    cmd.deriv_order   <= ORDER_W'(order);
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  // pick a setting; the first three are the extremes
  task automatic pick_setting(input int s);
    int k;
    case (s)
      0: begin
        set_degree   = 3'd5;
        set_duration = '1;
        for (k = 0; k < NUM_TERMS; k++) set_coef[k] = 32'h7FFF_FFFF;
      end
      1: begin
        set_degree   = 3'd7;
        set_duration = '1;
        for (k = 0; k < NUM_TERMS; k++) set_coef[k] = 32'h8000_0000;
      end
      2: begin
        set_degree   = 3'd0;
        set_duration = '0;
        for (k = 0; k < NUM_TERMS; k++) set_coef[k] = $urandom;
      end
      default: begin
        set_degree = DEG_W'($urandom_range(7));
        if ($urandom_range(2) != 0) begin
          set_duration = TIME_W'($urandom_range(0, 32'h6_0000));
        end else begin
          set_duration = TIME_W'($urandom);
        end
        // mostly small coefficients so values stay in range and rounding shows
        for (k = 0; k < NUM_TERMS; k++) begin
          if ($urandom_range(3) == 0) begin
            set_coef[k] = $urandom;
          end else begin
            set_coef[k] = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
          end
        end
      end
    endcase
  endtask

  // random time: mostly inside [0, duration], some negative, above and wild
  function automatic logic [DATA_W-1:0] pick_time();
    logic [DATA_W-1:0] tp;
    case ($urandom_range(9))
      0: tp = $urandom;
      1: tp = {1'b1, 31'($urandom)};
      2: tp = {1'b0, set_duration} + $urandom_range(1, 32'h4_0000);
      default: tp = {1'b0, 31'($urandom_range(0, int'({1'b0, set_duration})))};
    endcase
    return tp;
  endfunction

  initial begin
    int s;
    int i;
    int deg_eff;
    int sent;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // registers straight out of reset
    issue_cmd(32'h0001_0000, 0);

    // saturation everywhere, time below zero and at the duration limit, every order
    set_degree   = 3'd5;
    set_duration = '1;
    set_coef = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                 32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF};
    load_setting();
    issue_cmd(32'h8000_0000, 0);
    issue_cmd(32'h0000_0000, 0);
    issue_cmd(32'h7FFF_FFFF, 0);
    for (i = 1; i < 8; i++) begin
      issue_cmd(32'h0001_0000, i);
    end

    // half-way ties in rounding, clamp to duration, order above degree
    set_degree   = 3'd3;
    set_duration = 31'h2_0000;
    set_coef = '{32'h0001_8000, 32'hFFFF_0000, 32'h0000_0001,
                 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    load_setting();
    issue_cmd(32'h0000_8000, 1);
    issue_cmd(32'h0000_8000, 0);
    issue_cmd(32'h7FFF_FFFF, 0);
    issue_cmd(32'hFFFF_FFFF, 0);
    issue_cmd(32'h0002_0000, 3);
    issue_cmd(32'h0002_0000, 4);
    issue_cmd(32'h0002_0000, 7);

    // degree register above the maximum, zero duration
    set_degree   = 3'd7;
    set_duration = '0;
    set_coef = '{32'h0000_1000, 32'h0000_2000, 32'hFFFF_C000,
                 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FF00};
    load_setting();
    issue_cmd(32'h1234_5678, 0);
    issue_cmd(32'h0000_0000, 5);
    issue_cmd(32'h0000_0000, 6);

    // constant polynomial
    set_degree   = 3'd0;
    set_duration = '1;
    load_setting();
    issue_cmd(32'h4000_0000, 0);
    issue_cmd(32'h4000_0000, 1);

    // random settings, sender idling 18% then 77% then never
    sent = 0;
    for (s = 0; s < RAND_SETTINGS; s++) begin
      pick_setting(s);
      load_setting();
      deg_eff = (int'(set_degree) > MAX_DEGREE) ? MAX_DEGREE : int'(set_degree);
      for (i = 0; i < CMDS_PER_SET; i++) begin
        if (sent < RAND_SETTINGS * CMDS_PER_SET / 3) begin
          idle_pct = 18;
        end else if (sent < 2 * RAND_SETTINGS * CMDS_PER_SET / 3) begin
          idle_pct = 77;
        end else begin
          idle_pct = 0;
        end
        if ($urandom_range(4) == 0) begin
          issue_cmd(pick_time(), $urandom_range(7));
        end else begin
          issue_cmd(pick_time(), $urandom_range(0, deg_eff));
        end
        sent++;
      end
    end

    // drain, then allow for stray beats
    start <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_LAT + 4) @(negedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/pde_pkg.sv
hdl/pde_prep.sv
hdl/pde_step.sv
hdl/poly_derivative_eval.sv
bench/pde_checker.sv
bench/tb_poly_derivative_eval.sv
